// ----- rtl/tecl_pkg.sv -----
// Shared types and constants for the tracking error command limiter.
// No dependencies; imported by the limiter and its port checker.
package tecl_pkg;

    localparam int FRAC_BITS_DEF   = 12;
    localparam int CMD_W           = 16;
    localparam int ERR_W           = 16;
    localparam int LIMIT_W         = 15;
    localparam int MIN_SCALE_W     = 13;
    localparam int CFG_ADDR_W      = 5;
    localparam int CFG_DATA_W      = 32;
    localparam int SMALL_SPEED_LSB = 4;

    localparam logic [LIMIT_W-1:0]     RST_MAX_SPEED     = 15'd2458;
    localparam logic [LIMIT_W-1:0]     RST_MAX_YAW_RATE  = 15'd4915;
    localparam logic [ERR_W-1:0]       RST_SLOWDOWN_ERR  = 16'd819;
    localparam logic [ERR_W-1:0]       RST_STOP_ERR      = 16'd2253;
    localparam logic [MIN_SCALE_W-1:0] RST_MIN_SPD_SCALE = 13'd1024;
    localparam logic [LIMIT_W-1:0]     RST_MIN_EFF_SPEED = 15'd901;

    // register index = byte address / 4
    typedef enum logic [2:0] {
        REG_MAX_SPEED       = 3'd0,
        REG_MAX_YAW_RATE    = 3'd1,
        REG_SLOWDOWN_ERROR  = 3'd2,
        REG_STOP_ERROR      = 3'd3,
        REG_MIN_SPEED_SCALE = 3'd4,
        REG_MIN_EFF_SPEED   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [CMD_W-1:0] cmd_speed;
        logic signed [CMD_W-1:0] cmd_yaw_rate;
        logic [ERR_W-1:0]        track_error;
    } t_in_beat;

    typedef struct packed {
        logic signed [CMD_W-1:0] out_speed;
        logic signed [CMD_W-1:0] out_yaw_rate;
    } t_out_beat;

endpackage

// ----- rtl/tracking_error_command_limiter.sv -----
// Tracking error command limiter: clamps and scales speed / yaw commands.
// Depends on tecl_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one command
//   beat: speed, yaw rate and tracking error. Output channel (o_out_valid /
//   i_out_stall / o_out_data) returns one limited beat per input beat, in order.
//   The APB port holds the six limit registers at byte addresses 0x00..0x14;
//   write them only while no beat is in flight.
//   Pipeline: one input stage, one stage per quotient bit of the scale
//   divider, one multiply stage and the output register.
//   Throughput: one beat per cycle while no result is held by i_out_stall;
//   a new beat can enter in every such cycle.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   default limits.
//   Stall: while a result is held with i_out_stall high, the whole pipeline
//   freezes and o_in_stall is raised in the same cycle; nothing is lost or
//   repeated, bubbles are kept.
module tracking_error_command_limiter #(
    parameter int FRAC_BITS = tecl_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tecl_pkg::t_in_beat                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tecl_pkg::t_out_beat                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tecl_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [tecl_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [tecl_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import tecl_pkg::*;

    localparam int SW        = (FRAC_BITS > MIN_SCALE_W) ? FRAC_BITS : MIN_SCALE_W;
    localparam int SPW       = LIMIT_W + SW;          // speed product width
    localparam int YPW       = LIMIT_W + FRAC_BITS;   // yaw product width
    localparam int SMW       = SPW + 1 - FRAC_BITS;   // rounded speed magnitude
    localparam int YMW       = YPW + 1 - FRAC_BITS;
    localparam int YAW_FLOOR = ((1 << FRAC_BITS) + 5) / 10;

    localparam logic [SPW:0]     SHALF     = (SPW+1)'(1) << (FRAC_BITS - 1);
    localparam logic [YPW:0]     YHALF     = (YPW+1)'(1) << (FRAC_BITS - 1);
    localparam logic [FRAC_BITS-1:0] YFLOOR_Q = FRAC_BITS'(YAW_FLOOR);
    localparam logic [SMW-1:0]   POS_MAX   = SMW'(32767);
    localparam logic [SMW-1:0]   NEG_MAX   = SMW'(32768);
    localparam logic [SMW-1:0]   SMALL_MAG = SMW'(SMALL_SPEED_LSB);

    typedef struct packed {
        logic                 spd_neg;
        logic [LIMIT_W-1:0]   spd_mag;
        logic                 yaw_neg;
        logic [LIMIT_W-1:0]   yaw_mag;
        logic                 pass;
        logic                 zero;
        logic [ERR_W-1:0]     rem;
        logic [ERR_W-1:0]     den;
        logic [FRAC_BITS-1:0] quo;
    } t_stage;

    typedef struct packed {
        logic                 spd_neg;
        logic [LIMIT_W-1:0]   spd_mag;
        logic                 yaw_neg;
        logic [LIMIT_W-1:0]   yaw_mag;
        logic                 pass;
        logic                 zero;
        logic [SPW-1:0]       sprod;
        logic [YPW-1:0]       yprod;
    } t_mul;

    // ---------------- configuration registers ----------------
    logic [LIMIT_W-1:0]     r_max_speed;
    logic [LIMIT_W-1:0]     r_max_yaw;
    logic [ERR_W-1:0]       r_slow_err;
    logic [ERR_W-1:0]       r_stop_err;
    logic [MIN_SCALE_W-1:0] r_min_scale;
    logic [LIMIT_W-1:0]     r_min_eff;
    t_reg_idx               cfg_idx;

    assign cfg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= RST_MAX_SPEED;
            r_max_yaw   <= RST_MAX_YAW_RATE;
            r_slow_err  <= RST_SLOWDOWN_ERR;
            r_stop_err  <= RST_STOP_ERR;
            r_min_scale <= RST_MIN_SPD_SCALE;
            r_min_eff   <= RST_MIN_EFF_SPEED;
        end else if (psel && penable && pwrite && pready) begin
            case (cfg_idx)
                REG_MAX_SPEED:       r_max_speed <= pwdata[LIMIT_W-1:0];
                REG_MAX_YAW_RATE:    r_max_yaw   <= pwdata[LIMIT_W-1:0];
                REG_SLOWDOWN_ERROR:  r_slow_err  <= pwdata[ERR_W-1:0];
                REG_STOP_ERROR:      r_stop_err  <= pwdata[ERR_W-1:0];
                REG_MIN_SPEED_SCALE: r_min_scale <= pwdata[MIN_SCALE_W-1:0];
                REG_MIN_EFF_SPEED:   r_min_eff   <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MAX_SPEED:       prdata = CFG_DATA_W'(r_max_speed);
            REG_MAX_YAW_RATE:    prdata = CFG_DATA_W'(r_max_yaw);
            REG_SLOWDOWN_ERROR:  prdata = CFG_DATA_W'(r_slow_err);
            REG_STOP_ERROR:      prdata = CFG_DATA_W'(r_stop_err);
            REG_MIN_SPEED_SCALE: prdata = CFG_DATA_W'(r_min_scale);
            REG_MIN_EFF_SPEED:   prdata = CFG_DATA_W'(r_min_eff);
            default:             prdata = '0;
        endcase
    end

    // ---------------- helpers ----------------
    function automatic logic [LIMIT_W-1:0] f_clamp_mag(logic signed [CMD_W-1:0] v,
                                                      logic [LIMIT_W-1:0] lim);
        logic [CMD_W-1:0] absv;
        absv = v[CMD_W-1] ? CMD_W'(-v) : CMD_W'(v);
        return (absv > CMD_W'(lim)) ? lim : absv[LIMIT_W-1:0];
    endfunction

    // one restoring-division step: one quotient bit
    function automatic t_stage f_div_step(t_stage s);
        t_stage         o;
        logic [ERR_W:0] t;
        logic           ge;
        o  = s;
        t  = {s.rem, 1'b0};
        ge = (t >= {1'b0, s.den});
        o.rem = ge ? ERR_W'(t - {1'b0, s.den}) : t[ERR_W-1:0];
        o.quo = {s.quo[FRAC_BITS-2:0], ge};
        return o;
    endfunction

    function automatic logic signed [CMD_W-1:0] f_signed_sat(logic neg, logic [SMW-1:0] mag);
        logic signed [CMD_W-1:0] res;
        if (neg) begin
            res = (mag >= NEG_MAX) ? 16'sh8000 : CMD_W'(-mag[CMD_W-1:0]);
        end else begin
            res = (mag > POS_MAX) ? 16'sh7FFF : mag[CMD_W-1:0];
        end
        return res;
    endfunction

    // ---------------- pipeline control ----------------
    logic pipe_en;
    assign pipe_en    = !(o_out_valid && i_out_stall);
    assign o_in_stall = !pipe_en;

    // ---------------- stage 0: clamp and classify ----------------
    t_stage n_st [0:FRAC_BITS];
    t_stage r_st [0:FRAC_BITS];
    logic [FRAC_BITS:0] r_st_vld;

    always_comb begin
        logic [ERR_W-1:0] diff;
        diff = r_stop_err - r_slow_err;
        n_st[0].spd_neg = i_in_data.cmd_speed[CMD_W-1];
        n_st[0].spd_mag = f_clamp_mag(i_in_data.cmd_speed, r_max_speed);
        n_st[0].yaw_neg = i_in_data.cmd_yaw_rate[CMD_W-1];
        n_st[0].yaw_mag = f_clamp_mag(i_in_data.cmd_yaw_rate, r_max_yaw);
        n_st[0].pass    = (i_in_data.track_error <= r_slow_err);
        n_st[0].zero    = (i_in_data.track_error >= r_stop_err);
        n_st[0].rem     = r_stop_err - i_in_data.track_error;
        n_st[0].den     = (diff == '0) ? ERR_W'(1) : diff;
        n_st[0].quo     = '0;
    end

    // ---------------- stages 1..FRAC_BITS: scale divider ----------------
    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_div
        assign n_st[k] = f_div_step(r_st[k-1]);
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            for (int k = 0; k <= FRAC_BITS; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // ---------------- multiply stage ----------------
    t_mul              n_mul;
    t_mul              r_mul;
    logic              r_mul_vld;

    always_comb begin
        logic [SW-1:0]        raw_w;
        logic [SW-1:0]        sscale;
        logic [FRAC_BITS-1:0] yscale;
        raw_w  = SW'(r_st[FRAC_BITS].quo);
        sscale = (raw_w > SW'(r_min_scale)) ? raw_w : SW'(r_min_scale);
        yscale = (r_st[FRAC_BITS].quo > YFLOOR_Q) ? r_st[FRAC_BITS].quo : YFLOOR_Q;
        n_mul.spd_neg = r_st[FRAC_BITS].spd_neg;
        n_mul.spd_mag = r_st[FRAC_BITS].spd_mag;
        n_mul.yaw_neg = r_st[FRAC_BITS].yaw_neg;
        n_mul.yaw_mag = r_st[FRAC_BITS].yaw_mag;
        n_mul.pass    = r_st[FRAC_BITS].pass;
        n_mul.zero    = r_st[FRAC_BITS].zero;
        n_mul.sprod   = SPW'(r_st[FRAC_BITS].spd_mag) * SPW'(sscale);
        n_mul.yprod   = YPW'(r_st[FRAC_BITS].yaw_mag) * YPW'(yscale);
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_mul <= n_mul;
        end
    end

    // ---------------- round, floor, saturate, output register ----------------
    t_out_beat n_out;
    t_out_beat r_out;
    logic      r_out_vld;

    always_comb begin
        logic [SPW:0]   ssum;
        logic [YPW:0]   ysum;
        logic [SMW-1:0] smag;
        logic [YMW-1:0] ymag;
        ssum = {1'b0, r_mul.sprod} + SHALF;
        ysum = {1'b0, r_mul.yprod} + YHALF;
        smag = ssum[SPW:FRAC_BITS];
        ymag = ysum[YPW:FRAC_BITS];
        // lift slow speeds above SMALL_SPEED_LSB to the minimum effective speed
        if (smag > SMALL_MAG && smag < SMW'(r_min_eff)) begin
            smag = SMW'(r_min_eff);
        end
        if (r_mul.pass) begin
            n_out.out_speed    = f_signed_sat(r_mul.spd_neg, SMW'(r_mul.spd_mag));
            n_out.out_yaw_rate = f_signed_sat(r_mul.yaw_neg, SMW'(r_mul.yaw_mag));
        end else if (r_mul.zero) begin
            n_out.out_speed    = '0;
            n_out.out_yaw_rate = '0;
        end else begin
            n_out.out_speed    = f_signed_sat(r_mul.spd_neg, smag);
            n_out.out_yaw_rate = f_signed_sat(r_mul.yaw_neg, SMW'(ymag));
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_out <= n_out;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld  <= '0;
            r_mul_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (pipe_en) begin
            r_st_vld  <= {r_st_vld[FRAC_BITS-1:0], i_in_valid};
            r_mul_vld <= r_st_vld[FRAC_BITS];
            r_out_vld <= r_mul_vld;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/tecl_checker.sv -----
// Port-level checker for the tracking error command limiter, with its bind.
// Depends on tecl_pkg.
module tecl_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tecl_pkg::t_out_beat o_out_data
);
    import tecl_pkg::*;

    // a held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // input back-pressure only comes from a stalled result
    a_in_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output stall");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // yaw is clamped to a 15-bit limit, so it never reaches the negative rail
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.out_yaw_rate != 16'sh8000)
        else $error("yaw rate out of clamp range");

endmodule

bind tracking_error_command_limiter tecl_checker u_tecl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
